/* rtl/core/dqkp_pkg.sv */
// Shared types, operation codes and status codes of the deque with key purge.
`timescale 1ns / 1ps
`default_nettype none
package dqkp_pkg;

	localparam int unsigned CAPACITY = 1024;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PURGE      = 3'd4;
	localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] value;
	} dqkp_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic                is_mirror;
		logic [STATUS_W-1:0] status;
	} dqkp_out_t;

endpackage
`default_nettype wire

/* rtl/core/dqkp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dqkp_ram #(
	parameter int unsigned WIDTH = dqkp_pkg::DATA_W,
	parameter int unsigned DEPTH = dqkp_pkg::CAPACITY,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/deque_with_key_purge_unit.sv */
// Top level of the deque with key purge: control, ring pointers and result buffer.
// Usage: requests enter on in_valid/in_ready with in_data (mode, value); one result
// per request leaves on out_valid/out_ready with out_data (count, is_mirror, status).
// The entries live in two mirrored copies of a CAPACITY-deep ring RAM, so the
// palindrome walk can read the front and back ends in the same cycle.
// Push and pop finish in the cycle they are accepted; their result is registered
// into the output buffer, and requests of this kind can follow back to back while
// the buffer has room. A purge walks every held entry through the registered RAM
// read and returns the count of entries kept; no new request is taken until the
// walk ends and its result is pushed. A palindrome query walks the held / 2 pairs
// from both ends in the same manner.
// The walk length, one RAM read per entry or pair per cycle, bounds the throughput.
// Results pass through a two-entry output buffer, so a request is still taken
// while one result waits for the receiver; when two results wait, in_ready drops.
// Reset empties the deque (front and length zero) and the output buffer; the RAM
// content is not cleared, since only held entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module deque_with_key_purge_unit #(
	parameter int unsigned CAPACITY = dqkp_pkg::CAPACITY
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire dqkp_pkg::dqkp_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output dqkp_pkg::dqkp_out_t      out_data
);

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned OUT_W = dqkp_pkg::COUNT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PURGE = 3'b010,
		ST_QUERY = 3'b100
	} state_t;

	function automatic logic [OUT_W-1:0] to_count(input logic [CNT_W-1:0] n);
		logic [CNT_W+OUT_W-1:0] ext;
		ext = {{OUT_W{1'b0}}, n};
		return ext[OUT_W-1:0];
	endfunction

	state_t                         state_q;
	logic [IDX_W-1:0]               front_q;
	logic [CNT_W-1:0]               held_q;
	logic [IDX_W-1:0]               ptr_a_q;
	logic [IDX_W-1:0]               ptr_b_q;
	logic [IDX_W-1:0]               wr_ptr_q;
	logic [CNT_W-1:0]               left_q;
	logic [CNT_W-1:0]               kept_q;
	logic [dqkp_pkg::DATA_W-1:0]    key_q;
	logic                           mism_q;
	logic                           walk_s1;

	logic                           out_valid_q;
	dqkp_pkg::dqkp_out_t            out_q;
	logic                           spare_valid_q;
	dqkp_pkg::dqkp_out_t            spare_q;

	logic                           accept;
	logic                           full;
	logic                           empty;
	logic [IDX_W-1:0]               front_inc;
	logic [IDX_W-1:0]               front_dec;
	logic [IDX_W-1:0]               ptr_a_inc;
	logic [IDX_W-1:0]               ptr_b_dec;
	logic [IDX_W-1:0]               wr_ptr_inc;
	logic [IDX_W:0]                 back_sum;
	logic [IDX_W-1:0]               back_slot;
	logic [CNT_W-1:0]               held_m1;
	logic [IDX_W:0]                 last_sum;
	logic [IDX_W-1:0]               last_slot;

	logic                           ram_we;
	logic [IDX_W-1:0]               ram_waddr;
	logic [dqkp_pkg::DATA_W-1:0]    ram_wdata;
	logic [dqkp_pkg::DATA_W-1:0]    rdata_a;
	logic [dqkp_pkg::DATA_W-1:0]    rdata_b;
	logic                           keep_word;

	logic                           walk_done;
	logic                           res_push;
	dqkp_pkg::dqkp_out_t            res;
	logic [CNT_W-1:0]               held_d;
	logic [IDX_W-1:0]               front_d;
	logic                           take;

	assign in_ready  = (state_q == ST_IDLE) && !spare_valid_q;
	assign accept    = in_valid && in_ready;
	assign full      = (held_q == CAP_CNT);
	assign empty     = (held_q == '0);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign take      = out_valid_q && out_ready;

	assign front_inc  = (front_q == LAST_IDX) ? '0 : front_q + IDX_W'(1);
	assign front_dec  = (front_q == '0) ? LAST_IDX : front_q - IDX_W'(1);
	assign ptr_a_inc  = (ptr_a_q == LAST_IDX) ? '0 : ptr_a_q + IDX_W'(1);
	assign ptr_b_dec  = (ptr_b_q == '0) ? LAST_IDX : ptr_b_q - IDX_W'(1);
	assign wr_ptr_inc = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + IDX_W'(1);

	// Ring position of offset n is front + n, folded once since both are below CAPACITY.
	assign back_sum  = {1'b0, front_q} + {1'b0, held_q[IDX_W-1:0]};
	assign back_slot = (back_sum >= CAP_SUM) ? IDX_W'(back_sum - CAP_SUM) : back_sum[IDX_W-1:0];
	assign held_m1   = held_q - CNT_W'(1);
	assign last_sum  = {1'b0, front_q} + {1'b0, held_m1[IDX_W-1:0]};
	assign last_slot = (last_sum >= CAP_SUM) ? IDX_W'(last_sum - CAP_SUM) : last_sum[IDX_W-1:0];

	assign keep_word = (rdata_a != key_q);
	assign walk_done = (state_q != ST_IDLE) && (left_q == '0) && !walk_s1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q;
		ram_wdata = rdata_a;
		if (accept && !full && (in_data.mode == dqkp_pkg::MODE_PUSH_BACK)) begin
			ram_we    = 1'b1;
			ram_waddr = back_slot;
			ram_wdata = in_data.value;
		end else if (accept && !full && (in_data.mode == dqkp_pkg::MODE_PUSH_FRONT)) begin
			ram_we    = 1'b1;
			ram_waddr = front_dec;
			ram_wdata = in_data.value;
		end else if ((state_q == ST_PURGE) && walk_s1 && keep_word) begin
			ram_we = 1'b1;
		end
	end

	// Next state and result of push and pop, and the result of a finished purge or query walk.
	always_comb begin
		held_d        = held_q;
		front_d       = front_q;
		res_push      = 1'b0;
		res.count     = to_count(held_q);
		res.is_mirror = 1'b0;
		res.status    = dqkp_pkg::STAT_OK;
		if (accept) begin
			res_push = 1'b1;
			case (in_data.mode)
				dqkp_pkg::MODE_PUSH_BACK: begin
					if (full) begin
						res.status = dqkp_pkg::STAT_FULL;
					end else begin
						held_d = held_q + CNT_W'(1);
					end
				end
				dqkp_pkg::MODE_PUSH_FRONT: begin
					if (full) begin
						res.status = dqkp_pkg::STAT_FULL;
					end else begin
						held_d  = held_q + CNT_W'(1);
						front_d = front_dec;
					end
				end
				dqkp_pkg::MODE_POP_FRONT: begin
					if (empty) begin
						res.status = dqkp_pkg::STAT_EMPTY;
					end else begin
						held_d  = held_m1;
						front_d = front_inc;
					end
				end
				dqkp_pkg::MODE_POP_BACK: begin
					if (empty) begin
						res.status = dqkp_pkg::STAT_EMPTY;
					end else begin
						held_d = held_m1;
					end
				end
				dqkp_pkg::MODE_PURGE: begin
					res_push = 1'b0;
				end
				dqkp_pkg::MODE_QUERY: begin
					res_push = 1'b0;
				end
				default: begin
				end
			endcase
			res.count = to_count(held_d);
		end else if (walk_done) begin
			res_push = 1'b1;
			if (state_q == ST_PURGE) begin
				held_d    = kept_q;
				res.count = to_count(kept_q);
			end else begin
				res.is_mirror = !mism_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			held_q  <= '0;
			left_q  <= '0;
			walk_s1 <= 1'b0;
		end else begin
			front_q <= front_d;
			held_q  <= held_d;
			case (state_q)
				ST_IDLE: begin
					walk_s1 <= 1'b0;
					if (accept && (in_data.mode == dqkp_pkg::MODE_PURGE)) begin
						state_q <= ST_PURGE;
						left_q  <= held_q;
					end else if (accept && (in_data.mode == dqkp_pkg::MODE_QUERY)) begin
						state_q <= ST_QUERY;
						left_q  <= held_q >> 1;
					end
				end
				ST_PURGE, ST_QUERY: begin
					walk_s1 <= (left_q != '0);
					if (left_q != '0) begin
						left_q <= left_q - CNT_W'(1);
					end
					if (walk_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk pointers and accumulators.
	always_ff @(posedge clk) begin
		if (accept) begin
			ptr_a_q  <= front_q;
			ptr_b_q  <= last_slot;
			wr_ptr_q <= front_q;
			kept_q   <= '0;
			key_q    <= in_data.value;
			mism_q   <= 1'b0;
		end else begin
			if (left_q != '0) begin
				ptr_a_q <= ptr_a_inc;
				ptr_b_q <= ptr_b_dec;
			end
			if ((state_q == ST_PURGE) && walk_s1 && keep_word) begin
				wr_ptr_q <= wr_ptr_inc;
				kept_q   <= kept_q + CNT_W'(1);
			end
			if ((state_q == ST_QUERY) && walk_s1 && (rdata_a != rdata_b)) begin
				mism_q <= 1'b1;
			end
		end
	end

	// Two-entry result buffer; a push only ever arrives while the spare entry is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q   <= spare_valid_q || res_push;
			spare_valid_q <= 1'b0;
		end else begin
			spare_valid_q <= spare_valid_q || res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_q <= spare_valid_q ? spare_q : res;
		end else if (res_push) begin
			spare_q <= res;
		end
	end

	dqkp_ram #(
		.WIDTH(dqkp_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram_a (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_a_q),
		.rdata(rdata_a)
	);

	dqkp_ram #(
		.WIDTH(dqkp_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram_b (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_b_q),
		.rdata(rdata_b)
	);

endmodule
`default_nettype wire
